FILE: rtl/rrsp_pkg.sv
// ---------------------------------------------------------------------------
// rrsp_pkg
// Shared types and constants for the reply stream parser: byte classes,
// parser phases, reply type and event codes, and the queue word.
// ---------------------------------------------------------------------------
package rrsp_pkg;

	localparam int LEN_BITS_DEF = 32;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [3:0] {
		CLS_DIGIT,
		CLS_CR,
		CLS_LF,
		CLS_PLUS,
		CLS_MINUS,
		CLS_COLON,
		CLS_DOLLAR,
		CLS_STAR,
		CLS_OTHER
	} cls_t;

	typedef enum logic [3:0] {
		PH_TYPE,
		PH_LINE,
		PH_NUMFIRST,
		PH_NUM,
		PH_NUMLF,
		PH_DATA,
		PH_SKIP,
		PH_ELEMHDR,
		PH_SKIPLF
	} phase_t;

	typedef enum logic [2:0] {
		RT_STRING,
		RT_ERROR,
		RT_INTEGER,
		RT_BULK,
		RT_LIST,
		RT_UNKNOWN
	} rtype_t;

	typedef enum logic [2:0] {
		EV_LIST_HDR,
		EV_VALUE,
		EV_NULL,
		EV_EMPTY,
		EV_UNKNOWN
	} event_t;

	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
	} rrsp_word_t;

endpackage

FILE: rtl/rrsp_if.sv
// ---------------------------------------------------------------------------
// rrsp_if
// Valid/ready channels for the incoming byte stream and the parsed results.
// ---------------------------------------------------------------------------
interface rrsp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rrsp_reply_if;
	logic               valid;
	logic               ready;
	logic [2:0]         reply_type;
	logic [2:0]         event_res;
	logic [7:0]         value_byte;
	logic signed [31:0] element_count;
	logic [30:0]        element_index;
	logic               last_of_value;
	logic               last_of_reply;

	modport source (
		output valid, output reply_type, output event_res, output value_byte,
		output element_count, output element_index, output last_of_value,
		output last_of_reply, input ready
	);
	modport sink (
		input valid, input reply_type, input event_res, input value_byte,
		input element_count, input element_index, input last_of_value,
		input last_of_reply, output ready
	);
endinterface

FILE: rtl/rrsp_classify.sv
// ---------------------------------------------------------------------------
// rrsp_classify
// Front end: accepts stream bytes and tags each word with its byte class.
// ---------------------------------------------------------------------------
module rrsp_classify
	import rrsp_pkg::*;
(
	rrsp_rx_if.sink    rx,
	output logic       push_valid,
	input  logic       push_ready,
	output rrsp_word_t push_word
);

	cls_t cls;

	always_comb begin
		if (rx.rx_byte >= CH_ZERO && rx.rx_byte <= CH_NINE) begin
			cls = CLS_DIGIT;
		end else begin
			unique case (rx.rx_byte)
				CH_CR:     cls = CLS_CR;
				CH_LF:     cls = CLS_LF;
				CH_PLUS:   cls = CLS_PLUS;
				CH_MINUS:  cls = CLS_MINUS;
				CH_COLON:  cls = CLS_COLON;
				CH_DOLLAR: cls = CLS_DOLLAR;
				CH_STAR:   cls = CLS_STAR;
				default:   cls = CLS_OTHER;
			endcase
		end
	end

	assign push_valid     = rx.valid;
	assign rx.ready       = push_ready;
	assign push_word.data = rx.rx_byte;
	assign push_word.cls  = cls;

endmodule

FILE: rtl/rrsp_fifo.sv
// ---------------------------------------------------------------------------
// rrsp_fifo
// Short word queue between the classifier and the parser.
// ---------------------------------------------------------------------------
module rrsp_fifo
	import rrsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  rrsp_word_t push_word,
	output logic       pop_valid,
	input  logic       pop_ready,
	output rrsp_word_t pop_word
);

	rrsp_word_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rrsp_parser.sv
// ---------------------------------------------------------------------------
// rrsp_parser
// Back end: reply framing state machine with a registered result stage.
// ---------------------------------------------------------------------------
module rrsp_parser
	import rrsp_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  rrsp_word_t   pop_word,
	rrsp_reply_if.source reply
);

	localparam int NB = (LEN_BITS > 32) ? 32 : LEN_BITS;
	localparam int NW = NB - 1;

	phase_t        phase_q, phase_n;
	rtype_t        type_q, type_n;
	logic [NW-1:0] acc_q, acc_n;
	logic          neg_q, neg_n;
	logic          malf_q, malf_n;
	logic [NW-1:0] left_q, left_n;
	logic [NW-1:0] cnt_q, cnt_n;
	logic [NW-1:0] bytes_q, bytes_n;
	logic [1:0]    skip_q, skip_n;
	logic [7:0]    held_q, held_n;
	logic          held_v_q, held_v_n;

	logic          emit;
	rtype_t        r_type;
	event_t        r_event;
	logic [7:0]    r_byte;
	logic [31:0]   r_count;
	logic [NW-1:0] r_index;
	logic          r_lov;
	logic          r_lor;

	logic          out_valid_q;
	logic          advance;
	logic          in_list;
	logic [NW+3:0] acc_x10;
	logic [NW-1:0] acc_sat;
	logic [NW-1:0] left_dec;
	logic [NW-1:0] bytes_dec;
	logic [1:0]    skip_dec;
	logic          last_elem;

	assign advance   = pop_valid && (!out_valid_q || reply.ready);
	assign pop_ready = !out_valid_q || reply.ready;
	assign in_list   = (type_q == RT_LIST);
	assign acc_x10   = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ (NW+4)'(pop_word.data[3:0]);
	assign acc_sat   = (acc_x10[NW+3:NW] != '0) ? '1 : acc_x10[NW-1:0];
	assign left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;
	assign bytes_dec = (bytes_q != '0) ? bytes_q - 1'b1 : bytes_q;
	assign skip_dec  = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
	assign last_elem = (left_q <= NW'(1));

	always_comb begin
		phase_n  = phase_q;
		type_n   = type_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		malf_n   = malf_q;
		left_n   = left_q;
		cnt_n    = cnt_q;
		bytes_n  = bytes_q;
		skip_n   = skip_q;
		held_n   = held_q;
		held_v_n = held_v_q;
		emit     = 1'b0;
		r_type   = type_q;
		r_event  = EV_VALUE;
		r_byte   = '0;
		r_count  = '0;
		r_index  = '0;
		r_lov    = 1'b0;
		r_lor    = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				left_n   = '0;
				cnt_n    = '0;
				held_v_n = 1'b0;
				case (pop_word.cls) inside
					CLS_PLUS, CLS_MINUS, CLS_COLON: begin
						type_n  = (pop_word.cls == CLS_PLUS) ? RT_STRING :
							(pop_word.cls == CLS_MINUS) ? RT_ERROR : RT_INTEGER;
						phase_n = PH_LINE;
					end
					CLS_DOLLAR, CLS_STAR: begin
						type_n  = (pop_word.cls == CLS_DOLLAR) ? RT_BULK : RT_LIST;
						acc_n   = '0;
						neg_n   = 1'b0;
						malf_n  = 1'b0;
						phase_n = PH_NUMFIRST;
					end
					default: begin
						type_n  = RT_UNKNOWN;
						phase_n = (pop_word.cls == CLS_LF) ? PH_TYPE : PH_SKIPLF;
						emit    = 1'b1;
						r_type  = RT_UNKNOWN;
						r_event = EV_UNKNOWN;
						r_lov   = 1'b1;
						r_lor   = 1'b1;
					end
				endcase
			end
			PH_LINE: begin
				if (pop_word.cls == CLS_CR) begin
					skip_n   = 2'd1;
					phase_n  = PH_SKIP;
					held_v_n = 1'b0;
					emit     = 1'b1;
					r_event  = held_v_q ? EV_VALUE : EV_EMPTY;
					r_byte   = held_v_q ? held_q : 8'd0;
					r_lov    = 1'b1;
					r_lor    = 1'b1;
				end else begin
					held_n   = pop_word.data;
					held_v_n = 1'b1;
					emit     = held_v_q;
					r_event  = EV_VALUE;
					r_byte   = held_q;
				end
			end
			PH_NUMFIRST, PH_NUM: begin
				phase_n = PH_NUM;
				if (pop_word.cls == CLS_CR) begin
					if (malf_q || (neg_q && acc_q != NW'(1))) begin
						acc_n = '0;
						neg_n = 1'b0;
					end
					phase_n = PH_NUMLF;
				end else if (pop_word.cls == CLS_DIGIT) begin
					acc_n = acc_sat;
				end else if (pop_word.cls == CLS_MINUS && phase_q == PH_NUMFIRST) begin
					neg_n = 1'b1;
				end else begin
					malf_n = 1'b1;
				end
			end
			PH_NUMLF: begin
				if (in_list && left_q == '0) begin
					emit    = 1'b1;
					r_type  = RT_LIST;
					r_event = EV_LIST_HDR;
					r_lov   = 1'b1;
					if (neg_q) begin
						phase_n = PH_TYPE;
						r_count = '1;
						r_lor   = 1'b1;
					end else if (acc_q == '0) begin
						phase_n = PH_TYPE;
						r_lor   = 1'b1;
					end else begin
						left_n  = acc_q;
						cnt_n   = '0;
						phase_n = PH_ELEMHDR;
						r_count = 32'(acc_q);
					end
				end else if (neg_q || acc_q == '0) begin
					emit    = 1'b1;
					r_event = neg_q ? EV_NULL : EV_EMPTY;
					r_index = in_list ? cnt_q : '0;
					r_lov   = 1'b1;
					r_lor   = in_list ? last_elem : 1'b1;
					if (in_list) begin
						left_n = left_dec;
						cnt_n  = cnt_q + 1'b1;
					end
					if (neg_q) begin
						phase_n = (in_list && left_dec != '0) ? PH_ELEMHDR : PH_TYPE;
					end else begin
						skip_n  = 2'd2;
						phase_n = PH_SKIP;
					end
				end else begin
					bytes_n = acc_q;
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				bytes_n = bytes_dec;
				emit    = 1'b1;
				r_event = EV_VALUE;
				r_byte  = pop_word.data;
				r_index = in_list ? cnt_q : '0;
				if (bytes_dec == '0) begin
					r_lov   = 1'b1;
					r_lor   = in_list ? last_elem : 1'b1;
					skip_n  = 2'd2;
					phase_n = PH_SKIP;
					if (in_list) begin
						left_n = left_dec;
						cnt_n  = cnt_q + 1'b1;
					end
				end
			end
			PH_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					phase_n = (in_list && left_q != '0) ? PH_ELEMHDR : PH_TYPE;
				end
			end
			PH_ELEMHDR: begin
				acc_n   = '0;
				neg_n   = 1'b0;
				malf_n  = 1'b0;
				phase_n = PH_NUMFIRST;
			end
			PH_SKIPLF: begin
				if (pop_word.cls == CLS_LF) begin
					phase_n = PH_TYPE;
				end
			end
			default: begin
				phase_n = PH_TYPE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			type_q      <= RT_STRING;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			malf_q      <= 1'b0;
			left_q      <= '0;
			cnt_q       <= '0;
			bytes_q     <= '0;
			skip_q      <= '0;
			held_q      <= '0;
			held_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_n;
				type_q      <= type_n;
				acc_q       <= acc_n;
				neg_q       <= neg_n;
				malf_q      <= malf_n;
				left_q      <= left_n;
				cnt_q       <= cnt_n;
				bytes_q     <= bytes_n;
				skip_q      <= skip_n;
				held_q      <= held_n;
				held_v_q    <= held_v_n;
				out_valid_q <= emit;
			end else if (reply.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			reply.reply_type    <= r_type;
			reply.event_res     <= r_event;
			reply.value_byte    <= r_byte;
			reply.element_count <= r_count;
			reply.element_index <= 31'(r_index);
			reply.last_of_value <= r_lov;
			reply.last_of_reply <= r_lor;
		end
	end

	assign reply.valid = out_valid_q;

	a_lor_implies_lov: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reply.last_of_reply |-> reply.last_of_value)
		else $error("reply end without value end");

	a_unknown_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reply.event_res == EV_UNKNOWN |-> reply.reply_type == RT_UNKNOWN)
		else $error("unrecognized event with a known type");

	a_byte_only_on_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reply.value_byte != 8'd0 |-> reply.event_res == EV_VALUE)
		else $error("value byte on a non-value event");

	a_count_only_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reply.element_count != 32'sd0 |-> reply.event_res == EV_LIST_HDR)
		else $error("element count outside a list header");

	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> bytes_q != '0)
		else $error("data phase with no bytes left");

endmodule

FILE: rtl/resp_reply_stream_parser_unit.sv
// ---------------------------------------------------------------------------
// resp_reply_stream_parser_unit
// Path: a byte that is accepted is held in the word queue, and the result that it
// causes is then captured in the parser's result register, where it waits
// until the sink takes it.
// Throughput: one byte per cycle, stalled while a result waits on reply.ready.
// Reset: arst_n clears all control state asynchronously; no clearing pass.
// ---------------------------------------------------------------------------
module resp_reply_stream_parser_unit
	import rrsp_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rrsp_rx_if.sink      rx,
	rrsp_reply_if.source reply
);

	logic       push_valid;
	logic       push_ready;
	rrsp_word_t push_word;
	logic       pop_valid;
	logic       pop_ready;
	rrsp_word_t pop_word;

	rrsp_classify u_classify (
		.rx         (rx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	rrsp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	rrsp_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_word  (pop_word),
		.reply     (reply)
	);

endmodule
